FILE: rtl/core/rmfh_pkg.sv
// Package for the recursive mutex with FIFO handoff.
// Holds sizing constants, operation/status/state codes, payload structs
// and the ring slot helper. No dependencies.
`default_nettype none

package rmfh_pkg;

   // Sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int DEPTH_BITS  = 16;
   localparam int QA_BITS     = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [QA_BITS:0]      QUEUE_DEPTH_W = (QA_BITS + 1)'(QUEUE_DEPTH);
   localparam logic [FILL_BITS-1:0]  QUEUE_FULL    = FILL_BITS'(QUEUE_DEPTH);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX     = '1;

   // Request operations
   typedef enum logic [1:0] {
      FN_ACQUIRE = 2'd0,
      FN_TRY     = 2'd1,
      FN_RELEASE = 2'd2,
      FN_NONE    = 2'd3
   } func_type;

   // Result status codes
   typedef enum logic [2:0] {
      STS_OK         = 3'd0,
      STS_INVALID    = 3'd1,
      STS_BUSY       = 3'd2,
      STS_NOT_LOCKED = 3'd3,
      STS_NOT_OWNER  = 3'd4,
      STS_OVERFLOW   = 3'd5
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SEARCH,
      ST_HANDOFF
   } state_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] pid;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        queued;
      logic        locked;
      logic [7:0]  owner_id;
      logic [15:0] depth;
      logic [4:0]  waiting;
   } rsp_type;

   // Commands from the sequencer to the waiter ring
   typedef struct packed {
      logic               rd_en;
      logic [QA_BITS-1:0] rd_off;
      logic               push;
      logic [ID_BITS-1:0] push_id;
      logic               pop;
   } ring_cmd_type;

   // Physical slot of the entry at a given offset from the head
   function automatic logic [QA_BITS-1:0] rmfh_slot(input logic [QA_BITS-1:0] head,
                                                    input logic [QA_BITS-1:0] off);
      logic [QA_BITS:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= QUEUE_DEPTH_W) begin
         sum = sum - QUEUE_DEPTH_W;
      end
      return sum[QA_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rmfh_ring.sv
// Waiter ring of the recursive mutex: entry memory, head pointer and fill count.
// Depends on rmfh_pkg.
`default_nettype none

module rmfh_ring (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rmfh_pkg::ring_cmd_type        cmd,
   output logic [rmfh_pkg::ID_BITS-1:0]       rd_data,
   output logic [rmfh_pkg::FILL_BITS-1:0]     fill
);
   import rmfh_pkg::*;

   logic [ID_BITS-1:0]   mem [QUEUE_DEPTH];
   logic [ID_BITS-1:0]   rd_data_ff;
   logic [QA_BITS-1:0]   head_ff, head_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [QA_BITS-1:0]   rd_slot, wr_slot;

   // Map offsets to physical slots
   assign rd_slot = rmfh_slot(head_ff, cmd.rd_off);
   assign wr_slot = rmfh_slot(head_ff, fill_ff[QA_BITS-1:0]);

   // Advance head on pop, count pushes and pops
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.pop) begin
         head_in = rmfh_slot(head_ff, QA_BITS'(1));
         fill_in = fill_ff - FILL_BITS'(1);
      end else if (cmd.push) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Write at the tail, read with a registered port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_slot] <= cmd.push_id;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_slot];
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QUEUE_FULL)
      else $error("ring fill above capacity");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> fill_ff != QUEUE_FULL)
      else $error("push into full ring");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> fill_ff != '0 && !cmd.push)
      else $error("pop from empty ring or pop with push");

endmodule

`default_nettype wire

FILE: rtl/core/recursive_mutex_fifo_handoff.sv
// Top level of the recursive mutex with a FIFO of waiters and direct handoff.
// Depends on rmfh_pkg and rmfh_ring.
//
// Requests are accepted when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with rsp_strobe, and the receiver
// cannot stall it, so capture it on that cycle. A request keeps busy high
// while ST_DECIDE decides it, so no new request is taken until it is done; a
// release handing the lock to a waiter also goes through ST_HANDOFF. A blocking
// acquire that finds the lock held by another id with N waiters already queued
// (0 < N < QUEUE_DEPTH) walks the waiter ring one entry per cycle through the
// single ring read port to reject duplicates, keeping busy high through ST_DECIDE
// and ST_SEARCH. The result strobes in the first cycle with busy low.
// reserved_id is written through the csr_ channel, which is ready only while
// the block is idle and start is low.
`default_nettype none

module recursive_mutex_fifo_handoff (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire rmfh_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output rmfh_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_data
);
   import rmfh_pkg::*;

   state_type             state_ff, state_in;
   req_type               req_ff;
   logic [7:0]            reserved_ff;
   logic                  held_ff, held_in;
   logic [ID_BITS-1:0]    holder_ff, holder_in;
   logic [DEPTH_BITS-1:0] nest_ff, nest_in;
   logic [FILL_BITS-1:0]  issue_ff, issue_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   ring_cmd_type          ring_cmd;
   logic [ID_BITS-1:0]    ring_rd_data;
   logic [FILL_BITS-1:0]  ring_fill;
   logic [FILL_BITS-1:0]  fill_after;

   logic                  accept;
   logic                  done;
   logic                  go_search;
   logic                  go_handoff;
   logic [ID_BITS-1:0]    req_id;
   logic                  is_acq;
   status_type            status_v;
   logic                  queued_v;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign req_id    = req_ff.pid[ID_BITS-1:0];
   assign is_acq    = (req_ff.func == FN_ACQUIRE) || (req_ff.func == FN_TRY);

   rmfh_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .rd_data (ring_rd_data),
      .fill    (ring_fill)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (go_search) begin
               state_in = ST_SEARCH;
            end else if (go_handoff) begin
               state_in = ST_HANDOFF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         ST_HANDOFF: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Decide the request, drive the ring and update the lock
   always_comb begin
      held_in    = held_ff;
      holder_in  = holder_ff;
      nest_in    = nest_ff;
      issue_in   = issue_ff;
      ring_cmd   = '0;
      ring_cmd.push_id = req_id;
      status_v   = STS_OK;
      queued_v   = 1'b0;
      done       = 1'b0;
      go_search  = 1'b0;
      go_handoff = 1'b0;
      unique case (state_ff)
         ST_DECIDE: begin
            if (is_acq) begin
               priority if (req_id == reserved_ff[ID_BITS-1:0]) begin
                  status_v = STS_INVALID;
                  done     = 1'b1;
               end else if (!held_ff) begin
                  held_in   = 1'b1;
                  holder_in = req_id;
                  nest_in   = DEPTH_BITS'(1);
                  done      = 1'b1;
               end else if (holder_ff == req_id) begin
                  if (nest_ff == DEPTH_MAX) begin
                     status_v = STS_OVERFLOW;
                  end else begin
                     nest_in = nest_ff + DEPTH_BITS'(1);
                  end
                  done = 1'b1;
               end else if (req_ff.func == FN_TRY || ring_fill == QUEUE_FULL) begin
                  status_v = STS_BUSY;
                  done     = 1'b1;
               end else if (ring_fill == '0) begin
                  // empty ring: nothing to search, append now
                  status_v      = STS_BUSY;
                  queued_v      = 1'b1;
                  ring_cmd.push = 1'b1;
                  done          = 1'b1;
               end else begin
                  // fetch the head entry and start the duplicate search
                  ring_cmd.rd_en  = 1'b1;
                  ring_cmd.rd_off = '0;
                  issue_in        = FILL_BITS'(1);
                  go_search       = 1'b1;
               end
            end else if (req_ff.func == FN_RELEASE) begin
               priority if (!held_ff) begin
                  status_v = STS_NOT_LOCKED;
                  done     = 1'b1;
               end else if (holder_ff != req_id) begin
                  status_v = STS_NOT_OWNER;
                  done     = 1'b1;
               end else if (nest_ff > DEPTH_BITS'(1)) begin
                  nest_in = nest_ff - DEPTH_BITS'(1);
                  done    = 1'b1;
               end else if (ring_fill != '0) begin
                  // fetch the head waiter for handoff
                  ring_cmd.rd_en  = 1'b1;
                  ring_cmd.rd_off = '0;
                  go_handoff      = 1'b1;
               end else begin
                  held_in   = 1'b0;
                  holder_in = '0;
                  nest_in   = '0;
                  done      = 1'b1;
               end
            end else begin
               done = 1'b1;
            end
         end
         ST_SEARCH: begin
            status_v = STS_BUSY;
            if (ring_rd_data == req_id) begin
               done = 1'b1;
            end else if (issue_ff == ring_fill) begin
               queued_v      = 1'b1;
               ring_cmd.push = 1'b1;
               done          = 1'b1;
            end else begin
               ring_cmd.rd_en  = 1'b1;
               ring_cmd.rd_off = issue_ff[QA_BITS-1:0];
               issue_in        = issue_ff + FILL_BITS'(1);
            end
         end
         ST_HANDOFF: begin
            holder_in    = ring_rd_data;
            nest_in      = DEPTH_BITS'(1);
            ring_cmd.pop = 1'b1;
            done         = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Build the result from the state after this request
   always_comb begin
      fill_after = ring_fill;
      if (ring_cmd.push) begin
         fill_after = ring_fill + FILL_BITS'(1);
      end else if (ring_cmd.pop) begin
         fill_after = ring_fill - FILL_BITS'(1);
      end
      rsp_valid_in     = done;
      rsp_in.status    = status_v;
      rsp_in.queued    = queued_v;
      rsp_in.locked    = held_in;
      rsp_in.owner_id  = held_in ? 8'(holder_in) : 8'd0;
      rsp_in.depth     = held_in ? 16'(nest_in) : 16'd0;
      rsp_in.waiting   = 5'(fill_after);
   end

   // Control and lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= 1'b0;
         holder_ff    <= '0;
         nest_ff      <= '0;
         issue_ff     <= '0;
         reserved_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         holder_ff    <= holder_in;
         nest_ff      <= nest_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            reserved_ff <= csr_data;
         end
      end
   end

   // Capture the request and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe while busy");

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DECIDE)
      else $error("accepted request not decided");

   a_unlocked_clear: assert property (@(posedge clock) disable iff (reset)
      !held_ff |-> nest_ff == '0 && holder_ff == '0)
      else $error("unlocked with owner or depth");

   a_locked_depth: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> nest_ff != '0)
      else $error("locked at depth zero");

endmodule

`default_nettype wire
